// ----- rtl/sha256_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sha256 package
// Round constants, initial hash values and controller/datapath command types.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef logic [31:0] word_t;

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [2:0] FULL_COUNT = 3'd4;

    // what the datapath writes into the schedule slot this cycle
    typedef enum logic [2:0] {
        WSRC_DATA,  // raw input word
        WSRC_PAD,   // masked data with 0x80 marker
        WSRC_ZERO,
        WSRC_LEN,   // length word, high or low half by slot
        WSRC_MARK   // lone 0x80 marker after a full last word
    } wsrc_t;

    typedef struct packed {
        logic       wr_en;
        logic [3:0] wr_idx;
        wsrc_t      wr_src;
        logic       len_add;   // add input bits to length
        logic       load_vars; // copy chain into working vars
        logic       round_en;
        logic [5:0] round;
        logic       fold;      // add working vars into chain
        logic       shift_out; // rotate chain for output
        logic       clear;     // back to initial values
    } dp_cmd_t;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

// ----- rtl/sha256_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sha256 datapath
// Schedule window, working variables, chaining words and length counter.
// ----------------------------------------------------------------------------
module sha256_datapath
    import sha256_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire dp_cmd_t        cmd,
    input  wire word_t          in_data,
    input  wire logic [2:0]     in_count,
    output word_t               out_word
);

    word_t       w_reg [16];
    word_t       v_reg [8];
    word_t       h_reg [8];
    logic [63:0] len_reg;

    word_t w_next_round, wt, t1, t2, s0, s1, x, y, keep, pad_word, wr_word;
    logic [4:0] sh;

    always_comb begin
        x  = w_reg[cmd.round[3:0] + 4'd1];
        y  = w_reg[cmd.round[3:0] + 4'd14];
        s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
        s1 = rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10);
        w_next_round = w_reg[cmd.round[3:0]] + s0 + w_reg[cmd.round[3:0] + 4'd9] + s1;
        wt = (cmd.round[5:4] == 2'd0) ? w_reg[cmd.round[3:0]] : w_next_round;
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + wt + ROUND_K[cmd.round];
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        // count is 0..3 whenever the pad word is used
        sh   = {in_count[1:0], 3'd0};
        keep = (in_count[1:0] == 2'd0) ? '0 : ~(32'hffffffff >> sh);
        pad_word = (in_data & keep) | (32'h80000000 >> sh);
        unique case (cmd.wr_src)
            WSRC_DATA: wr_word = in_data;
            WSRC_PAD:  wr_word = pad_word;
            WSRC_ZERO: wr_word = '0;
            WSRC_LEN:  wr_word = cmd.wr_idx[0] ? len_reg[31:0] : len_reg[63:32];
            WSRC_MARK: wr_word = 32'h80000000;
            default:   wr_word = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            w_reg[cmd.wr_idx] <= wr_word;
        end else if (cmd.round_en && cmd.round[5:4] != 2'd0) begin
            w_reg[cmd.round[3:0]] <= w_next_round;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            h_reg   <= INIT_H;
            v_reg   <= '{default: '0};
            len_reg <= '0;
        end else begin
            if (cmd.len_add) begin
                len_reg <= len_reg + {58'd0, in_count, 3'd0};
            end
            if (cmd.load_vars) begin
                v_reg <= h_reg;
            end else if (cmd.round_en) begin
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
            end
            if (cmd.fold) begin
                for (int i = 0; i < 8; i++) begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end else if (cmd.shift_out) begin
                for (int i = 0; i < 7; i++) begin
                    h_reg[i] <= h_reg[i+1];
                end
                h_reg[7] <= h_reg[0];
            end
        end
    end

    assign out_word = h_reg[0];

endmodule
`default_nettype wire

// ----- rtl/sha256_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sha256 controller
// Accepts beats, sequences padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl
    import sha256_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] in_count_raw,
    input  wire logic       in_last,
    output logic [2:0]      in_count,
    output dp_cmd_t         cmd,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      out_index,
    output logic            out_last
);

    typedef enum logic [2:0] {
        ST_IN, ST_LOAD, ST_ROUND, ST_FOLD, ST_FILL, ST_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] idx_reg, idx_next;
    logic [5:0] round_reg, round_next;
    logic       fin_reg, fin_next;   // padding started, length must follow
    logic       done_reg, done_next; // length written, this block is the final one
    logic       spill_reg, spill_next; // marker in slot 14, length needs a new block
    logic [2:0] oidx_reg, oidx_next;
    logic       pend_reg;            // last beat arrived, fold goes on to padding
    logic       acc;

    assign in_count = (!in_last || in_count_raw > FULL_COUNT) ? FULL_COUNT : in_count_raw;
    assign in_ready = (state_reg == ST_IN);
    assign acc      = in_valid && in_ready;
    assign out_valid = (state_reg == ST_OUT);
    assign out_index = oidx_reg;
    assign out_last  = (oidx_reg == 3'd7);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        round_next = round_reg;
        fin_next   = fin_reg;
        done_next  = done_reg;
        spill_next = spill_reg;
        oidx_next  = oidx_reg;
        cmd        = '0;
        cmd.wr_idx = idx_reg;
        cmd.wr_src = WSRC_DATA;
        cmd.round  = round_reg;
        unique case (state_reg)
            ST_IN: begin
                if (acc) begin
                    cmd.wr_en   = 1'b1;
                    cmd.len_add = 1'b1;
                    cmd.wr_src  = (in_count == FULL_COUNT) ? WSRC_DATA : WSRC_PAD;
                    idx_next    = idx_reg + 4'd1;
                    if (in_last) begin
                        fin_next   = 1'b1;
                        state_next = ST_FILL;
                        // full last word: marker goes in the next slot
                        if (in_count == FULL_COUNT) begin
                            fin_next = 1'b0;
                        end else if (idx_reg == 4'd14) begin
                            spill_next = 1'b1;
                        end
                        if (idx_reg == 4'd15) begin
                            state_next = ST_LOAD;
                        end
                    end else if (idx_reg == 4'd15) begin
                        state_next = ST_LOAD;
                    end
                    if (in_last) begin
                        done_next = 1'b0;
                    end
                end
            end
            ST_FILL: begin
                // fin_reg low: marker word still owed
                cmd.wr_en = 1'b1;
                if (!fin_reg) begin
                    cmd.wr_src = WSRC_MARK;
                    fin_next   = 1'b1;
                    idx_next   = idx_reg + 4'd1;
                    if (idx_reg == 4'd14) spill_next = 1'b1;
                    if (idx_reg == 4'd15) state_next = ST_LOAD;
                end else if (spill_reg) begin
                    // no room for the length: zero the last slot, compress
                    cmd.wr_src = WSRC_ZERO;
                    idx_next   = idx_reg + 4'd1;
                    spill_next = 1'b0;
                    state_next = ST_LOAD;
                end else if (idx_reg >= 4'd14) begin
                    cmd.wr_src = WSRC_LEN;
                    idx_next   = idx_reg + 4'd1;
                    if (idx_reg == 4'd15) begin
                        done_next  = 1'b1;
                        state_next = ST_LOAD;
                    end
                end else begin
                    cmd.wr_src = WSRC_ZERO;
                    idx_next   = idx_reg + 4'd1;
                end
            end
            ST_LOAD: begin
                cmd.load_vars = 1'b1;
                round_next    = '0;
                state_next    = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == 6'd63) state_next = ST_FOLD;
            end
            ST_FOLD: begin
                cmd.fold = 1'b1;
                if (done_reg) begin
                    oidx_next  = '0;
                    state_next = ST_OUT;
                end else if (fin_reg || pend_reg) begin
                    state_next = ST_FILL;
                end else begin
                    state_next = ST_IN;
                end
            end
            ST_OUT: begin
                if (out_ready) begin
                    cmd.shift_out = 1'b1;
                    oidx_next     = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7) begin
                        cmd.clear  = 1'b1;
                        cmd.shift_out = 1'b0;
                        idx_next   = '0;
                        fin_next   = 1'b0;
                        done_next  = 1'b0;
                        spill_next = 1'b0;
                        state_next = ST_IN;
                    end
                end
            end
            default: state_next = ST_IN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IN;
            idx_reg   <= '0;
            round_reg <= '0;
            fin_reg   <= 1'b0;
            done_reg  <= 1'b0;
            spill_reg <= 1'b0;
            oidx_reg  <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            round_reg <= round_next;
            fin_reg   <= fin_next;
            done_reg  <= done_next;
            spill_reg <= spill_next;
            oidx_reg  <= oidx_next;
            if (acc && in_last) begin
                pend_reg <= 1'b1;
            end else if (state_reg == ST_OUT) begin
                pend_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_round_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && round_reg == 6'd63) |=> state_reg == ST_FOLD)
        else $error("round count did not end compression");
    a_no_out_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> !in_ready)
        else $error("input open during digest output");
    a_out_after_fold: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid) |-> $past(state_reg) == ST_FOLD && oidx_reg == 3'd0)
        else $error("digest output not preceded by final fold");
    a_len_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_en && cmd.wr_src == WSRC_LEN) |-> idx_reg >= 4'd14)
        else $error("length written outside its slots");
`endif

endmodule
`default_nettype wire

// ----- rtl/sha256_message_digest.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sha256 message digest
// Streams a big-endian message in, returns the eight SHA-256 digest words.
// ----------------------------------------------------------------------------
// One beat is taken per cycle while a block is being gathered; each full
// 16-word block then runs 64 rounds, one per cycle on the single round unit,
// plus a load step and a fold step. The last beat adds padding writes, one
// or two compressions, and eight digest beats on m_.
module sha256_message_digest
    import sha256_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // data_word[31:0], byte_count[34:32], zero fill
    input  wire logic        s_tlast,  // last_word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // digest_word[31:0], word_index[34:32], zero fill
    output logic             m_tlast   // digest_last
);

    dp_cmd_t    cmd;
    logic [2:0] count;
    logic [2:0] oidx;
    word_t      dword;

    sha256_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_count_raw (s_tdata[34:32]),
        .in_last      (s_tlast),
        .in_count     (count),
        .cmd          (cmd),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_index    (oidx),
        .out_last     (m_tlast)
    );

    sha256_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_data  (s_tdata[31:0]),
        .in_count (count),
        .out_word (dword)
    );

    assign m_tdata = {5'd0, oidx, dword};

endmodule
`default_nettype wire
